[rtl/core/sorted_set_table_defines.svh]
// Assertion helpers shared by the sorted set table RTL.
// All checks run on clk and are masked while rst is high.
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// Same-cycle implication check.
`define SST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_set_table: same-cycle check failed");

// Next-cycle implication check.
`define SST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_set_table: next-cycle check failed");

`endif

[rtl/core/sst_pkg.sv]
`default_nettype none

package sst_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

  // Operation codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_FIND   = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // Status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_EXISTS    = 3'd1;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STATUS_EMPTY     = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;
  localparam logic [2:0] STATUS_BAD_POS   = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } sst_state_t;

  // Request transaction
  typedef struct packed {
    logic [1:0]          func;
    logic signed [31:0]  key_value;
    logic [6:0]          position;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [2:0]          status;
    logic [6:0]          found_position;
    logic signed [31:0]  read_value;
    logic [6:0]          entry_count;
  } rsp_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                capture;   // latch compare flags against key
    logic signed [31:0]  key;       // incoming key (valid with capture)
    logic [CMP_W-1:0]    pos;       // incoming read position
    logic                insert;    // shift right from the insert point
    logic                remove;    // shift left over the matching entry
    logic signed [31:0]  new_key;   // key to drop in on insert
  } cell_cmd_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                occ;
    logic                lt;
    logic signed [31:0]  value;
  } link_t;

  // Per-cell match flags seen by the controller
  typedef struct packed {
    logic eq;
    logic sel;
  } flags_t;

endpackage

`default_nettype wire

[rtl/core/sst_cell.sv]
`default_nettype none

module sst_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sst_pkg::cell_cmd_t         cmd,
  input  wire logic [sst_pkg::CMP_W-1:0]  slot,
  input  wire sst_pkg::link_t             left,
  input  wire sst_pkg::link_t             right,
  output sst_pkg::link_t                  self,
  output sst_pkg::flags_t                 flags,
  output logic signed [31:0]              read_out,
  output logic [sst_pkg::CMP_W-1:0]       found_out
);

  logic               occ;
  logic               lt;
  logic               eq;
  logic               sel;
  logic signed [31:0] value;

  // Flags and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      lt  <= 1'b0;
      eq  <= 1'b0;
      sel <= 1'b0;
    end else begin
      if (cmd.capture) begin
        lt  <= occ && (value < cmd.key);
        eq  <= occ && (value == cmd.key);
        sel <= (cmd.pos == slot);
      end
      if (cmd.insert && !lt) begin
        occ <= left.occ;
      end else if (cmd.remove && !lt) begin
        occ <= right.occ;
      end
    end
  end

  // Entry value: cells at or past the boundary shift
  always_ff @(posedge clk) begin
    if (cmd.insert && !lt) begin
      value <= left.lt ? cmd.new_key : left.value;
    end else if (cmd.remove && !lt) begin
      value <= right.value;
    end
  end

  assign self      = '{occ: occ, lt: lt, value: value};
  assign flags     = '{eq: eq, sel: sel};
  assign read_out  = sel ? value : '0;
  assign found_out = eq ? slot : '0;

endmodule

`default_nettype wire

[rtl/core/sorted_set_table.sv]
// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid/req_stall  | sst_pkg::req_t  (func, key_value, position)
// rsp     | out | rsp_valid/rsp_stall  | sst_pkg::rsp_t  (status, found_position, ...)
//
// For each request, every cell compares its entry with the key in the accept
// cycle; then, in the evaluate state, the row shifts one place and the response
// is registered. No new request is taken until that response is registered.
// A waiting response holds the shift step until rsp_stall drops.
// rst clears the count and all occupancy; entry values need no reset.
`default_nettype none
`include "sorted_set_table_defines.svh"

module sorted_set_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire sst_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output sst_pkg::rsp_t      rsp
);

  localparam int N = sst_pkg::CAPACITY;

  sst_pkg::sst_state_t       state, state_next;
  logic [sst_pkg::CNT_W-1:0] count, count_next;
  logic [1:0]                op_func;
  logic [6:0]                op_pos;
  logic signed [31:0]        op_key;
  logic                      rsp_valid_next;
  sst_pkg::rsp_t             rsp_next;

  logic                      req_accept;
  logic                      commit;
  logic                      do_insert;
  logic                      do_remove;
  sst_pkg::cell_cmd_t        cmd;

  sst_pkg::link_t            cell_link [N];
  sst_pkg::flags_t           cell_flags [N];
  logic signed [31:0]        cell_read [N];
  logic [sst_pkg::CMP_W-1:0] cell_found [N];
  logic [N-1:0]              eq_vec;
  logic [N-1:0]              lt_vec;
  logic [N-1:0]              occ_vec;

  logic                      any_eq;
  logic signed [31:0]        read_or;
  logic [sst_pkg::CMP_W-1:0] found_or;
  logic [sst_pkg::CMP_W-1:0] pos_ext;
  logic [sst_pkg::CMP_W-1:0] count_ext;

  localparam sst_pkg::link_t HEAD_LINK = '{occ: 1'b1, lt: 1'b1, value: '0};
  localparam sst_pkg::link_t TAIL_LINK = '{occ: 1'b0, lt: 1'b0, value: '0};

  assign req_stall  = (state != sst_pkg::ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign commit     = (state == sst_pkg::ST_EVAL) && (!rsp_valid || !rsp_stall);

  // Broadcast to the row
  assign cmd = '{capture: req_accept,
                 key:     req.key_value,
                 pos:     sst_pkg::CMP_W'(req.position),
                 insert:  commit && do_insert,
                 remove:  commit && do_remove,
                 new_key: op_key};

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    sst_pkg::link_t left_link;
    sst_pkg::link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = HEAD_LINK;
    end else begin : g_left
      assign left_link = cell_link[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_link = TAIL_LINK;
    end else begin : g_right
      assign right_link = cell_link[i+1];
    end

    sst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .slot      (sst_pkg::CMP_W'(i + 1)),
      .left      (left_link),
      .right     (right_link),
      .self      (cell_link[i]),
      .flags     (cell_flags[i]),
      .read_out  (cell_read[i]),
      .found_out (cell_found[i])
    );

    assign eq_vec[i]  = cell_flags[i].eq;
    assign lt_vec[i]  = cell_link[i].lt;
    assign occ_vec[i] = cell_link[i].occ;
  end

  // Collect match results (at most one cell answers)
  always_comb begin
    read_or  = '0;
    found_or = '0;
    for (int i = 0; i < N; i++) begin
      read_or  = read_or | cell_read[i];
      found_or = found_or | cell_found[i];
    end
  end

  assign any_eq    = |eq_vec;
  assign pos_ext   = sst_pkg::CMP_W'(op_pos);
  assign count_ext = sst_pkg::CMP_W'(count);

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sst_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_func <= req.func;
      op_pos  <= req.position;
      op_key  <= req.key_value;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  // Next state, decision and response
  always_comb begin
    state_next     = state;
    count_next     = count;
    do_insert      = 1'b0;
    do_remove      = 1'b0;
    rsp_next       = '0;
    rsp_valid_next = rsp_valid && rsp_stall;

    unique case (op_func)
      sst_pkg::FUNC_ADD: begin
        if (any_eq) begin
          rsp_next.status = sst_pkg::STATUS_EXISTS;
        end else if (count == sst_pkg::CNT_W'(N)) begin
          rsp_next.status = sst_pkg::STATUS_FULL;
        end else begin
          rsp_next.status = sst_pkg::STATUS_OK;
          do_insert       = 1'b1;
        end
      end
      sst_pkg::FUNC_REMOVE: begin
        if (count == '0) begin
          rsp_next.status = sst_pkg::STATUS_EMPTY;
        end else if (any_eq) begin
          rsp_next.status = sst_pkg::STATUS_OK;
          do_remove       = 1'b1;
        end else begin
          rsp_next.status = sst_pkg::STATUS_NOT_FOUND;
        end
      end
      sst_pkg::FUNC_FIND: begin
        if (count == '0) begin
          rsp_next.status = sst_pkg::STATUS_EMPTY;
        end else if (any_eq) begin
          rsp_next.status         = sst_pkg::STATUS_OK;
          rsp_next.found_position = found_or[6:0];
        end else begin
          rsp_next.status = sst_pkg::STATUS_NOT_FOUND;
        end
      end
      sst_pkg::FUNC_READ: begin
        if (count == '0) begin
          rsp_next.status = sst_pkg::STATUS_EMPTY;
        end else if (op_pos == '0 || pos_ext > count_ext) begin
          rsp_next.status = sst_pkg::STATUS_BAD_POS;
        end else begin
          rsp_next.status     = sst_pkg::STATUS_OK;
          rsp_next.read_value = read_or;
        end
      end
      default: begin
        rsp_next.status = sst_pkg::STATUS_OK;
      end
    endcase

    unique case (state)
      sst_pkg::ST_IDLE: begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        if (req_accept) begin
          state_next = sst_pkg::ST_EVAL;
        end
      end
      sst_pkg::ST_EVAL: begin
        if (commit) begin
          state_next     = sst_pkg::ST_IDLE;
          rsp_valid_next = 1'b1;
          if (do_insert) begin
            count_next = count + 1'b1;
          end else if (do_remove) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        state_next = sst_pkg::ST_IDLE;
      end
    endcase

    rsp_next.entry_count = 7'(count_next);
  end

  // Checks
  `SST_ASSERT_IMP(a_count_cap, 1'b1, count <= sst_pkg::CNT_W'(N))
  `SST_ASSERT_IMP(a_occ_count, 1'b1, $countones(occ_vec) == count)
  `SST_ASSERT_IMP(a_one_match, state == sst_pkg::ST_EVAL, $onehot0(eq_vec))
  `SST_ASSERT_IMP(a_lt_prefix, state == sst_pkg::ST_EVAL, ((lt_vec >> 1) & ~lt_vec) == '0)
  `SST_ASSERT_NXT(a_accept_eval, req_accept, state == sst_pkg::ST_EVAL)

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam int POOL_SIZE = 48;
  localparam int PRINT_CAP = 40;

  // Tracks the contents of the table and the replies still owed by the block
  class sorted_set_tracker;
    logic signed [31:0] entries [CAPACITY];
    int                 stored;
    rsp_t               pending_replies [$];
    int                 errors;
    int                 checked;
    int                 peak;
    int                 status_hits [6];

    function new();
      foreach (entries[i]) entries[i] = '0;
      stored = 0;
      errors = 0;
      checked = 0;
      peak = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int stored_count();
      return stored;
    endfunction

    function logic signed [31:0] value_at(int i);
      return entries[i];
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Apply one operation to the tracked table and return the reply it owes
    function rsp_t predict_reply(req_t r);
      rsp_t               o;
      int                 idx;
      bit                 hit;
      logic signed [31:0] k;
      k = $signed(r.key_value);
      o = '0;
      idx = 0;
      while (idx < stored && $signed(entries[idx]) < k) idx++;
      hit = (idx < stored) && (entries[idx] == k);
      o.status = STATUS_OK;
      case (r.func)
        FUNC_ADD: begin
          if (hit) begin
            o.status = STATUS_EXISTS;
          end else if (stored >= CAPACITY) begin
            o.status = STATUS_FULL;
          end else begin
            for (int i = stored; i > idx; i--) entries[i] = entries[i-1];
            entries[idx] = k;
            stored++;
          end
        end
        FUNC_REMOVE: begin
          if (stored == 0) begin
            o.status = STATUS_EMPTY;
          end else if (hit) begin
            for (int i = idx; i < stored - 1; i++) entries[i] = entries[i+1];
            stored--;
          end else begin
            o.status = STATUS_NOT_FOUND;
          end
        end
        FUNC_FIND: begin
          if (stored == 0) o.status = STATUS_EMPTY;
          else if (hit) o.found_position = 7'(idx + 1);
          else o.status = STATUS_NOT_FOUND;
        end
        default: begin
          if (stored == 0) o.status = STATUS_EMPTY;
          else if (r.position == 0 || int'(r.position) > stored) o.status = STATUS_BAD_POS;
          else o.read_value = entries[r.position - 1];
        end
      endcase
      o.entry_count = 7'(stored);
      if (stored > peak) peak = stored;
      status_hits[o.status]++;
      return o;
    endfunction

    // Called for every accepted request transaction
    function void note_request(req_t r);
      pending_replies.push_back(predict_reply(r));
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("tb_top: mismatch at %0t: %s", $realtime, what);
    endtask

    // Called for every accepted response transaction
    task check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected response %p", got));
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.found_position !== want.found_position)
          report($sformatf("found_position %0d, want %0d",
                           got.found_position, want.found_position));
        if (got.read_value !== want.read_value)
          report($sformatf("read_value %0d, want %0d", got.read_value, want.read_value));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count %0d, want %0d", got.entry_count, want.entry_count));
      end
    endtask
  endclass

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  sorted_set_tracker tracker = new();

  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 growing;
  int                 full_hits;
  int                 empty_hits;
  logic signed [31:0] key_pool [POOL_SIZE];

  sorted_set_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: random stall, check every accepted transaction
  always @(negedge clk) begin
    rsp_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) tracker.check_response(rsp);
  end

  // Entered and left at a falling edge; payload holds until accepted
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [1:0] f, input logic signed [31:0] k,
                         input logic [6:0] p);
    req_t r;
    r.func      = f;
    r.key_value = k;
    r.position  = p;
    send_request(r);
  endtask

  // Short walk through the corner cases on a nearly empty table
  task automatic run_directed();
    send_op(FUNC_READ,   32'sd0, 7'd1);
    send_op(FUNC_FIND,   32'sd0, 7'd0);
    send_op(FUNC_REMOVE, 32'sd5, 7'd0);
    send_op(FUNC_ADD,    32'sh8000_0000, 7'd0);
    send_op(FUNC_ADD,    32'sh7fff_ffff, 7'd0);
    send_op(FUNC_ADD,    32'sd0, 7'd0);
    send_op(FUNC_ADD,    -32'sd1, 7'd0);
    send_op(FUNC_ADD,    32'sd0, 7'd0);
    send_op(FUNC_FIND,   32'sh8000_0000, 7'd0);
    send_op(FUNC_FIND,   32'sh7fff_ffff, 7'd0);
    send_op(FUNC_FIND,   32'sd7, 7'd0);
    send_op(FUNC_REMOVE, 32'sd7, 7'd0);
    send_op(FUNC_READ,   32'sd0, 7'd0);
    send_op(FUNC_READ,   32'sd0, 7'd4);
    send_op(FUNC_READ,   32'sd0, 7'd5);
    send_op(FUNC_READ,   32'sd0, 7'd64);
    send_op(FUNC_READ,   32'sd0, 7'd1);
    send_op(FUNC_REMOVE, 32'sh7fff_ffff, 7'd0);
    send_op(FUNC_REMOVE, 32'sh8000_0000, 7'd0);
    send_op(FUNC_REMOVE, -32'sd1, 7'd0);
    send_op(FUNC_READ,   32'sd0, 7'd1);
    send_op(FUNC_REMOVE, 32'sd0, 7'd0);
    send_op(FUNC_READ,   32'sd0, 7'd0);
    send_op(FUNC_FIND,   -32'sd1, 7'd0);
  endtask

  // Random request that fills the table to capacity, then drains it again
  function automatic req_t pick_request();
    req_t r;
    int   n;
    int   roll;
    int   k;
    n = tracker.stored_count();
    if (growing && n >= CAPACITY && ++full_hits >= 12) begin
      growing = 1'b0;
      full_hits = 0;
    end
    if (!growing && n == 0 && ++empty_hits >= 4) begin
      growing = 1'b1;
      empty_hits = 0;
    end
    roll = $urandom_range(0, 99);
    if (growing) begin
      r.func = (roll < 65) ? FUNC_ADD : (roll < 75) ? FUNC_REMOVE :
               (roll < 88) ? FUNC_FIND : FUNC_READ;
    end else begin
      r.func = (roll < 5) ? FUNC_ADD : (roll < 75) ? FUNC_REMOVE :
               (roll < 88) ? FUNC_FIND : FUNC_READ;
    end
    k = $urandom_range(0, 99);
    if (r.func == FUNC_ADD) begin
      if (k < 10 && n > 0) r.key_value = tracker.value_at($urandom_range(0, n - 1));
      else if (k < 55) r.key_value = $urandom;
      else r.key_value = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      if (k < 50 && n > 0) r.key_value = tracker.value_at($urandom_range(0, n - 1));
      else if (k < 65) r.key_value = $urandom;
      else r.key_value = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    if ($urandom_range(0, 99) < 85)
      r.position = 7'($urandom_range(0, (n + 1 > CAPACITY) ? CAPACITY : n + 1));
    else
      r.position = 7'($urandom_range(0, CAPACITY));
    return r;
  endfunction

  task automatic run_random(input int items);
    repeat (items) send_request(pick_request());
  endtask

  // Watchdog
  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 18;
    recv_idle_pct = 69;
    growing = 1'b1;
    full_hits = 0;
    empty_hits = 0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh8000_0001;
    key_pool[2] = -32'sd1;
    key_pool[3] = 32'sd0;
    key_pool[4] = 32'sd1;
    key_pool[5] = 32'sh7fff_fffe;
    key_pool[6] = 32'sh7fff_ffff;
    for (int i = 7; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_random(185);
    send_idle_pct = 69;
    recv_idle_pct = 18;
    run_random(185);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(180);
    req_valid <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0) tracker.report("responses still outstanding");

    $display("tb_top: %0d response transactions compared, peak occupancy %0d of %0d",
             tracker.checked, tracker.peak, CAPACITY);
    $display("tb_top: status counts ok %0d exists %0d missing %0d empty %0d full %0d pos %0d",
             tracker.status_hits[STATUS_OK], tracker.status_hits[STATUS_EXISTS],
             tracker.status_hits[STATUS_NOT_FOUND], tracker.status_hits[STATUS_EMPTY],
             tracker.status_hits[STATUS_FULL], tracker.status_hits[STATUS_BAD_POS]);
    if (tracker.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
